### hdl/sbm_pkg.sv
// ----------------------------------------------------------------------------
// sbm_pkg
// Shared constants, band tables, state encoding and the command/status
// structs between the band meter controller and its datapath.
// ----------------------------------------------------------------------------
package sbm_pkg;

   localparam int NUM_BANDS     = 7;
   localparam int HISTORY_DEPTH = 6;
   localparam int MAX_BANDS     = 16;

   // field widths
   localparam int MAG_W    = 27;
   localparam int FREQ_W   = 15;
   localparam int NUMBER_W = 3;
   localparam int LVL_W    = 16;
   localparam int FRAC_W   = LVL_W - 2;

   // datapath widths
   localparam int SUM_W        = 40;
   localparam int DIV_W        = 10;
   localparam int PROD_W       = SUM_W + DIV_W;
   localparam int BAND_W       = $clog2(NUM_BANDS);
   localparam int TABLE_W      = $clog2(MAX_BANDS);
   localparam int CNT_W        = $clog2(HISTORY_DEPTH + 1);
   localparam int SLOT_W       = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
   localparam int HIST_ENTRIES = NUM_BANDS * HISTORY_DEPTH;
   localparam int ADDR_W       = $clog2(HIST_ENTRIES);
   localparam int ACC_W        = LVL_W + CNT_W;
   localparam int STEP_W       = $clog2(LVL_W);

   // 3.0 in Q2.14
   localparam logic [LVL_W-1:0] FULL_SCALE = LVL_W'(49152);

   // upper band edges in Hz; a bin belongs to the first band whose edge is above it
   localparam logic [FREQ_W-1:0] UPPER_EDGE [MAX_BANDS] = '{
      15'd100,  15'd250,  15'd500,  15'd700,  15'd900,  15'd1400, 15'd2000, 15'd2000,
      15'd2000, 15'd2000, 15'd2000, 15'd2000, 15'd2000, 15'd2000, 15'd2000, 15'd2000
   };

   // per-band divisors
   localparam logic [DIV_W-1:0] BAND_DIV [MAX_BANDS] = '{
      10'd200, 10'd150, 10'd250, 10'd200, 10'd200, 10'd500, 10'd600, 10'd1,
      10'd1,   10'd1,   10'd1,   10'd1,   10'd1,   10'd1,   10'd1,   10'd1
   };

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MAX_FIRST,
      ST_MAX_MUL,
      ST_MAX_CMP,
      ST_LVL_MUL,
      ST_LVL_LOAD,
      ST_LVL_DIV,
      ST_LVL_WR,
      ST_COMMIT,
      ST_AVG_START,
      ST_AVG_RD,
      ST_AVG_ADD,
      ST_AVG_LOAD,
      ST_AVG_DIV,
      ST_AVG_OUT
   } state_type;

   typedef struct packed {
      logic accum;         // add the transferred bin into its band sum
      logic band_clr;
      logic band_inc;
      logic max_load;      // take the current band as the running maximum
      logic max_upd;       // take the current band if its ratio is larger
      logic mul;
      logic div_load_lvl;
      logic div_load_avg;
      logic div_step;
      logic mem_wr;
      logic hist_commit;   // advance history slot/count, clear band sums
      logic frame_clr;
      logic frame_inc;
      logic acc_clr;
      logic acc_add;
      logic mem_rd;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic band_last;
      logic frame_last;
      logic div_done;
      logic prod_gt;
      logic out_free;
   } status_type;

endpackage

### hdl/sbm_if.sv
// ----------------------------------------------------------------------------
// sbm_req_if / sbm_rsp_if
// Valid/ready channels of the band meter: spectrum bins in, band levels out.
// ----------------------------------------------------------------------------
interface sbm_req_if import sbm_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [MAG_W-1:0]  bin_magnitude;
   logic [FREQ_W-1:0] bin_frequency;
   logic              end_of_frame;

   modport source (output valid, output bin_magnitude, output bin_frequency,
                   output end_of_frame, input ready);
   modport sink   (input valid, input bin_magnitude, input bin_frequency,
                   input end_of_frame, output ready);
endinterface

interface sbm_rsp_if import sbm_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [NUMBER_W-1:0] band_number;
   logic [LVL_W-1:0]    band_level;
   logic                last_band;

   modport source (output valid, output band_number, output band_level,
                   output last_band, input ready);
   modport sink   (input valid, input band_number, input band_level,
                   input last_band, output ready);
endinterface

### hdl/sbm_ram.sv
// ----------------------------------------------------------------------------
// sbm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module sbm_ram #(
   parameter int  WIDTH  = 16,
   parameter int  DEPTH  = 42,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### hdl/sbm_ctrl.sv
// ----------------------------------------------------------------------------
// sbm_ctrl
// Frame sequencer: bin intake, maximum search, level division and history
// write, then per-band history averaging and result hand-off.
// ----------------------------------------------------------------------------
module sbm_ctrl import sbm_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_end_of_frame,
   output logic       req_ready,
   output cmd_type    cmd,
   input  status_type status
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid && req_end_of_frame) state_in = ST_MAX_FIRST;
         end
         ST_MAX_FIRST: state_in = ST_MAX_MUL;
         ST_MAX_MUL:   state_in = ST_MAX_CMP;
         ST_MAX_CMP:   state_in = status.band_last ? ST_LVL_MUL : ST_MAX_MUL;
         ST_LVL_MUL:   state_in = ST_LVL_LOAD;
         ST_LVL_LOAD:  state_in = ST_LVL_DIV;
         ST_LVL_DIV: begin
            if (status.div_done) state_in = ST_LVL_WR;
         end
         ST_LVL_WR:    state_in = status.band_last ? ST_COMMIT : ST_LVL_MUL;
         ST_COMMIT:    state_in = ST_AVG_START;
         ST_AVG_START: state_in = ST_AVG_RD;
         ST_AVG_RD:    state_in = ST_AVG_ADD;
         ST_AVG_ADD:   state_in = status.frame_last ? ST_AVG_LOAD : ST_AVG_RD;
         ST_AVG_LOAD:  state_in = ST_AVG_DIV;
         ST_AVG_DIV: begin
            if (status.div_done) state_in = ST_AVG_OUT;
         end
         ST_AVG_OUT: begin
            if (status.out_free) state_in = status.band_last ? ST_IDLE : ST_AVG_START;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready    = 1'b1;
            cmd.accum    = req_valid;
            cmd.band_clr = 1'b1;
         end
         ST_MAX_FIRST: begin
            cmd.max_load = 1'b1;
            cmd.band_inc = 1'b1;
         end
         ST_MAX_MUL: cmd.mul = 1'b1;
         ST_MAX_CMP: begin
            cmd.max_upd  = 1'b1;
            cmd.band_clr = status.band_last;
            cmd.band_inc = !status.band_last;
         end
         ST_LVL_MUL:  cmd.mul = 1'b1;
         ST_LVL_LOAD: cmd.div_load_lvl = 1'b1;
         ST_LVL_DIV:  cmd.div_step = 1'b1;
         ST_LVL_WR: begin
            cmd.mem_wr   = 1'b1;
            cmd.band_clr = status.band_last;
            cmd.band_inc = !status.band_last;
         end
         ST_COMMIT: cmd.hist_commit = 1'b1;
         ST_AVG_START: begin
            cmd.acc_clr   = 1'b1;
            cmd.frame_clr = 1'b1;
         end
         ST_AVG_RD: cmd.mem_rd = 1'b1;
         ST_AVG_ADD: begin
            cmd.acc_add   = 1'b1;
            cmd.frame_inc = !status.frame_last;
         end
         ST_AVG_LOAD: cmd.div_load_avg = 1'b1;
         ST_AVG_DIV:  cmd.div_step = 1'b1;
         ST_AVG_OUT: begin
            cmd.out_load = status.out_free;
            cmd.band_inc = status.out_free && !status.band_last;
         end
         default: cmd = '0;
      endcase
   end

   // result register must be free (or emptying) when a new level lands in it
   a_out_load_free: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> status.out_free)
      else $error("level loaded over a result not yet transferred");

   // a history write always follows the last divider step
   a_wr_after_div: assert property (@(posedge clock) disable iff (reset)
      cmd.mem_wr |-> $past(cmd.div_step))
      else $error("history written without a finished division");

endmodule

### hdl/sbm_datapath.sv
// ----------------------------------------------------------------------------
// sbm_datapath
// Band sums, ratio multipliers, shared restoring divider, level history
// RAM, averaging accumulator and the result register.
// ----------------------------------------------------------------------------
module sbm_datapath import sbm_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic [MAG_W-1:0]    req_bin_magnitude,
   input  logic [FREQ_W-1:0]   req_bin_frequency,
   input  cmd_type             cmd,
   output status_type          status,
   input  logic                rsp_ready,
   output logic                rsp_valid,
   output logic [NUMBER_W-1:0] rsp_band_number,
   output logic [LVL_W-1:0]    rsp_band_level,
   output logic                rsp_last_band
);

   logic [SUM_W-1:0]    band_sums_ff [NUM_BANDS];
   logic [BAND_W-1:0]   band_idx_ff;
   logic [BAND_W-1:0]   hit_idx;
   logic [BAND_W-1:0]   rd_idx;
   logic                hit;
   logic [SUM_W-1:0]    sel_sum;
   logic [SUM_W:0]      wide_sum;
   logic [SUM_W-1:0]    sat_sum;
   logic [DIV_W-1:0]    sel_div;
   logic [SUM_W-1:0]    max_sum_ff;
   logic [DIV_W-1:0]    max_div_ff;
   logic                max_zero;
   logic [PROD_W-1:0]   prod_a_ff;
   logic [PROD_W-1:0]   prod_b_ff;
   logic [PROD_W+1:0]   triple;
   logic [PROD_W-1:0]   rem_ff;
   logic [PROD_W-1:0]   rem_in;
   logic [PROD_W-1:0]   divisor_ff;
   logic [PROD_W:0]     shifted;
   logic [PROD_W:0]     diff;
   logic                ge;
   logic [LVL_W-1:0]    bits_ff;
   logic [LVL_W-1:0]    quo_ff;
   logic [STEP_W-1:0]   step_ff;
   logic [SLOT_W-1:0]   slot_ff;
   logic [SLOT_W-1:0]   frame_idx_ff;
   logic [CNT_W-1:0]    count_ff;
   logic [ACC_W-1:0]    acc_ff;
   logic [ADDR_W-1:0]   wr_addr;
   logic [ADDR_W-1:0]   rd_addr;
   logic [LVL_W-1:0]    wr_level;
   logic [LVL_W-1:0]    rd_level;
   logic                out_valid_ff;
   logic [NUMBER_W-1:0] out_band_ff;
   logic [LVL_W-1:0]    out_level_ff;
   logic                out_last_ff;

   // ---- band decode: first band whose upper edge lies above the bin
   always_comb begin
      hit     = 1'b0;
      hit_idx = '0;
      for (int i = NUM_BANDS - 1; i >= 0; i--) begin
         if (req_bin_frequency < UPPER_EDGE[i]) begin
            hit     = 1'b1;
            hit_idx = BAND_W'(i);
         end
      end
   end

   // one read port on the sum array, shared by intake and frame processing
   assign rd_idx   = cmd.accum ? hit_idx : band_idx_ff;
   assign sel_sum  = band_sums_ff[rd_idx];
   assign sel_div  = BAND_DIV[TABLE_W'(band_idx_ff)];
   assign wide_sum = {1'b0, sel_sum} + (SUM_W+1)'(req_bin_magnitude);
   assign sat_sum  = wide_sum[SUM_W] ? '1 : wide_sum[SUM_W-1:0];

   always_ff @(posedge clock) begin
      if (reset || cmd.hist_commit) begin
         for (int i = 0; i < NUM_BANDS; i++) begin
            band_sums_ff[i] <= '0;
         end
      end else if (cmd.accum && hit) begin
         band_sums_ff[hit_idx] <= sat_sum;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.band_clr) begin
         band_idx_ff <= '0;
      end else if (cmd.band_inc) begin
         band_idx_ff <= band_idx_ff + BAND_W'(1);
      end
   end

   // ---- ratio products: S[i]*D[m] against S[m]*D[i]
   always_ff @(posedge clock) begin
      if (cmd.max_load || (cmd.max_upd && status.prod_gt)) begin
         max_sum_ff <= sel_sum;
         max_div_ff <= sel_div;
      end
      if (cmd.mul) begin
         prod_a_ff <= PROD_W'(sel_sum) * PROD_W'(max_div_ff);
         prod_b_ff <= PROD_W'(max_sum_ff) * PROD_W'(sel_div);
      end
   end

   assign max_zero = (max_sum_ff == '0);

   // ---- shared restoring divider, one quotient bit per cycle
   // Level: floor(3*num*2^14/den); num <= den so (3*num)>>2 < den and the
   // two low bits of 3*num plus 14 zeros are the bits still to bring down.
   assign triple  = (PROD_W+2)'({prod_a_ff, 1'b0}) + (PROD_W+2)'(prod_a_ff);
   assign shifted = {rem_ff, bits_ff[LVL_W-1]};
   assign diff    = shifted - {1'b0, divisor_ff};
   assign ge      = (shifted >= {1'b0, divisor_ff});
   assign rem_in  = ge ? diff[PROD_W-1:0] : shifted[PROD_W-1:0];

   always_ff @(posedge clock) begin
      if (cmd.div_load_lvl) begin
         rem_ff     <= triple[PROD_W+1:2];
         bits_ff    <= {triple[1:0], FRAC_W'(0)};
         divisor_ff <= prod_b_ff;
         step_ff    <= '0;
      end else if (cmd.div_load_avg) begin
         // average < 2^16, so the bits above the low 16 are already below count
         rem_ff     <= PROD_W'(acc_ff[ACC_W-1:LVL_W]);
         bits_ff    <= acc_ff[LVL_W-1:0];
         divisor_ff <= PROD_W'(count_ff);
         step_ff    <= '0;
      end else if (cmd.div_step) begin
         rem_ff  <= rem_in;
         bits_ff <= {bits_ff[LVL_W-2:0], 1'b0};
         quo_ff  <= {quo_ff[LVL_W-2:0], ge};
         step_ff <= step_ff + STEP_W'(1);
      end
   end

   // ---- level history
   assign wr_level = max_zero ? '0 : quo_ff;
   assign wr_addr  = ADDR_W'(32'(slot_ff) * NUM_BANDS + 32'(band_idx_ff));
   assign rd_addr  = ADDR_W'(32'(frame_idx_ff) * NUM_BANDS + 32'(band_idx_ff));

   sbm_ram #(
      .WIDTH (LVL_W),
      .DEPTH (HIST_ENTRIES)
   ) u_hist_ram (
      .clock   (clock),
      .wr_en   (cmd.mem_wr),
      .wr_addr (wr_addr),
      .wr_data (wr_level),
      .rd_en   (cmd.mem_rd),
      .rd_addr (rd_addr),
      .rd_data (rd_level)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff  <= '0;
         count_ff <= '0;
      end else if (cmd.hist_commit) begin
         slot_ff <= (slot_ff == SLOT_W'(HISTORY_DEPTH - 1)) ? '0 : slot_ff + SLOT_W'(1);
         if (count_ff != CNT_W'(HISTORY_DEPTH)) begin
            count_ff <= count_ff + CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.frame_clr) begin
         frame_idx_ff <= '0;
      end else if (cmd.frame_inc) begin
         frame_idx_ff <= frame_idx_ff + SLOT_W'(1);
      end
      if (cmd.acc_clr) begin
         acc_ff <= '0;
      end else if (cmd.acc_add) begin
         acc_ff <= acc_ff + ACC_W'(rd_level);
      end
   end

   // ---- result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         out_band_ff  <= NUMBER_W'(band_idx_ff);
         out_level_ff <= quo_ff;
         out_last_ff  <= status.band_last;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_band_number = out_band_ff;
   assign rsp_band_level  = out_level_ff;
   assign rsp_last_band   = out_last_ff;

   always_comb begin
      status.band_last  = (band_idx_ff == BAND_W'(NUM_BANDS - 1));
      status.frame_last = ((CNT_W'(frame_idx_ff) + CNT_W'(1)) == count_ff);
      status.div_done   = (step_ff == STEP_W'(LVL_W - 1));
      status.prod_gt    = (prod_a_ff > prod_b_ff);
      status.out_free   = !out_valid_ff || rsp_ready;
   end

   a_level_range: assert property (@(posedge clock) disable iff (reset)
      cmd.mem_wr |-> (wr_level <= FULL_SCALE))
      else $error("normalized level above full scale");

   a_hist_bounds: assert property (@(posedge clock) disable iff (reset)
      (count_ff <= CNT_W'(HISTORY_DEPTH)) && (32'(slot_ff) < HISTORY_DEPTH))
      else $error("history slot or count out of range");

   a_avg_nonempty: assert property (@(posedge clock) disable iff (reset)
      cmd.div_load_avg |-> (count_ff != '0))
      else $error("averaging over an empty history");

endmodule

### hdl/spectrum_band_meter.sv
// ----------------------------------------------------------------------------
// spectrum_band_meter
// Spectrum band meter: sums bin magnitudes into seven bands, normalizes
// each frame so the strongest band reads 3.0 (Q2.14), and emits the band
// levels averaged over up to the last six frames.
//
// req_bus carries one bin per transfer (magnitude, frequency in Hz, end of
// frame mark). Bins that do not close a frame are taken one per cycle.
// A bin with end_of_frame set starts frame processing; req_bus.ready stays
// low until the frame's last band level has been loaded into the result
// register. rsp_bus then carries seven transfers, bands 0..6, with
// last_band set on band 6.
// Frame processing runs a maximum search over the bands, then a level
// division in the shared one bit per cycle divider and a history write
// per band, a history commit, and per band an average over the N stored
// frames: each entry is read from the history RAM and added, and the sum
// is divided by N. A stalled receiver holds the result register and halts
// the sequencer until the transfer.
// Reset clears the band sums, the history count and slot and the result
// valid; the history RAM needs no clearing since only stored frames are read.
// ----------------------------------------------------------------------------
module spectrum_band_meter import sbm_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   sbm_req_if.sink    req_bus,
   sbm_rsp_if.source  rsp_bus
);

   cmd_type    cmd;
   status_type status;

   sbm_ctrl u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_bus.valid),
      .req_end_of_frame (req_bus.end_of_frame),
      .req_ready        (req_bus.ready),
      .cmd              (cmd),
      .status           (status)
   );

   sbm_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .req_bin_magnitude (req_bus.bin_magnitude),
      .req_bin_frequency (req_bus.bin_frequency),
      .cmd               (cmd),
      .status            (status),
      .rsp_ready         (rsp_bus.ready),
      .rsp_valid         (rsp_bus.valid),
      .rsp_band_number   (rsp_bus.band_number),
      .rsp_band_level    (rsp_bus.band_level),
      .rsp_last_band     (rsp_bus.last_band)
   );

endmodule

### tb/spectrum_band_meter_tb.sv
// ----------------------------------------------------------------------------
// spectrum_band_meter_tb
// Drives spectrum bins into the band meter and checks every band level.
// A scoreboard class keeps its own band sums and frame history and predicts
// the seven averaged levels of each frame. Directed frames cover band edges,
// dropped bins, silent and tied frames. Random frames follow, with random
// gaps and stalls on both channels, one long receiver stall and pauses of
// the sender until all levels are back.
// ----------------------------------------------------------------------------
module spectrum_band_meter_tb;
   import sbm_pkg::*;

   typedef bit [63:0] wide_type;

   typedef struct packed {
      bit [NUMBER_W-1:0] number;
      bit [LVL_W-1:0]    level;
      bit                last;
   } band_result_type;

   localparam int unsigned BAND_EDGE_HZ [NUM_BANDS] = '{100, 250, 500, 700, 900, 1400, 2000};
   localparam wide_type BAND_DIVISOR [NUM_BANDS] = '{200, 150, 250, 200, 200, 500, 600};
   localparam wide_type SUM_LIMIT = (64'd1 << SUM_W) - 64'd1;
   localparam int unsigned EDGE_PROBE_HZ [14] = '{99, 100, 249, 250, 499, 500, 699, 700,
                                                 899, 900, 1399, 1400, 1999, 2000};
   localparam int LONG_HOLD_AFTER = 70;
   localparam int LONG_HOLD_CYCLES = 1500;
   localparam int RANDOM_BINS = 130;

   class band_level_scoreboard;
      bit [SUM_W-1:0]  band_sum [NUM_BANDS];
      bit [LVL_W-1:0]  frame_levels [HISTORY_DEPTH][NUM_BANDS];
      int unsigned     frames_stored;
      int unsigned     next_slot;
      band_result_type expected_levels [$];
      int unsigned     mismatches;

      function new();
         foreach (band_sum[i]) band_sum[i] = '0;
         frames_stored = 0;
         next_slot = 0;
         mismatches = 0;
      endfunction

      // floor(3.0 * num / den) in Q2.14, num <= den
      function bit [LVL_W-1:0] q214_ratio(wide_type num, wide_type den);
         wide_type rem;
         wide_type quo;
         rem = num * 3;
         quo = rem / den;
         rem = rem % den;
         for (int k = 0; k < FRAC_W; k++) begin
            rem = rem << 1;
            quo = quo << 1;
            if (rem >= den) begin
               rem = rem - den;
               quo[0] = 1'b1;
            end
         end
         return quo[LVL_W-1:0];
      endfunction

      function int pending();
         return expected_levels.size();
      endfunction

      function void note_bin(bit [MAG_W-1:0] mag, bit [FREQ_W-1:0] freq, bit eof);
         wide_type        total;
         wide_type        num;
         wide_type        den;
         int unsigned     acc;
         int              peak;
         bit              placed;
         band_result_type item;
         placed = 1'b0;
         for (int i = 0; i < NUM_BANDS; i++) begin
            if (!placed && freq < BAND_EDGE_HZ[i]) begin
               placed = 1'b1;
               total = wide_type'(band_sum[i]) + wide_type'(mag);
               band_sum[i] = (total > SUM_LIMIT) ? SUM_LIMIT[SUM_W-1:0] : total[SUM_W-1:0];
            end
         end
         if (!eof) return;

         // first band with the largest sum/divisor wins ties
         peak = 0;
         for (int i = 1; i < NUM_BANDS; i++) begin
            if (wide_type'(band_sum[i]) * BAND_DIVISOR[peak] >
                wide_type'(band_sum[peak]) * BAND_DIVISOR[i])
               peak = i;
         end
         for (int i = 0; i < NUM_BANDS; i++) begin
            num = wide_type'(band_sum[i]) * BAND_DIVISOR[peak];
            den = wide_type'(band_sum[peak]) * BAND_DIVISOR[i];
            frame_levels[next_slot][i] = (band_sum[peak] == 0) ? '0 : q214_ratio(num, den);
         end
         next_slot = (next_slot + 1 >= HISTORY_DEPTH) ? 0 : next_slot + 1;
         if (frames_stored < HISTORY_DEPTH) frames_stored++;

         for (int i = 0; i < NUM_BANDS; i++) begin
            acc = 0;
            for (int j = 0; j < frames_stored; j++) acc += frame_levels[j][i];
            item.number = NUMBER_W'(i);
            item.level  = LVL_W'(acc / frames_stored);
            item.last   = (i == NUM_BANDS - 1);
            expected_levels.push_back(item);
            band_sum[i] = '0;
         end
      endfunction

      function void check_result(bit [NUMBER_W-1:0] number, bit [LVL_W-1:0] level, bit last);
         band_result_type want;
         if (expected_levels.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("mismatch @%0t: unexpected band %0d level %0d last %0d",
                        $time, number, level, last);
            return;
         end
         want = expected_levels.pop_front();
         if (want.number != number || want.level != level || want.last != last) begin
            mismatches++;
            if (mismatches <= 10)
               $display("mismatch @%0t: band %0d/%0d level %0d/%0d last %0d/%0d (exp/act)",
                        $time, want.number, number, want.level, level, want.last, last);
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   sbm_req_if req_bus ();
   sbm_rsp_if rsp_bus ();

   band_level_scoreboard sb;
   int levels_received = 0;
   int bins_sent = 0;
   bit sender_calm = 1'b0;

   spectrum_band_meter uut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_bus.valid && req_bus.ready)
            sb.note_bin(req_bus.bin_magnitude, req_bus.bin_frequency, req_bus.end_of_frame);
         if (rsp_bus.valid && rsp_bus.ready) begin
            sb.check_result(rsp_bus.band_number, rsp_bus.band_level, rsp_bus.last_band);
            levels_received++;
         end
      end
   end

   // receiver: short random stalls, calm stretches, one long hold-off
   initial begin : level_sink
      int  stall_left;
      int  calm_left;
      bit  long_hold_done;
      stall_left = 0;
      calm_left = 0;
      long_hold_done = 1'b0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (!long_hold_done && levels_received >= LONG_HOLD_AFTER) begin
            long_hold_done = 1'b1;
            stall_left = LONG_HOLD_CYCLES;
         end
         if (calm_left == 0 && $urandom_range(0, 99) == 0) calm_left = $urandom_range(50, 150);
         if (stall_left > 0) begin
            rsp_bus.ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_bus.ready <= 1'b1;
            if (calm_left > 0)
               calm_left--;
            else if ($urandom_range(0, 3) == 0)
               stall_left = ($urandom_range(0, 15) == 0) ? $urandom_range(20, 60)
                                                         : $urandom_range(1, 3);
         end
      end
   end

   task automatic send_bin(input bit [MAG_W-1:0] mag, input bit [FREQ_W-1:0] freq,
                           input bit eof);
      int gap;
      if (!sender_calm && $urandom_range(0, 4) == 0) begin
         gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
         repeat (gap) begin
            @(negedge clock);
            req_bus.valid         <= 1'b0;
            req_bus.bin_magnitude <= MAG_W'($urandom);
            req_bus.bin_frequency <= FREQ_W'($urandom);
            req_bus.end_of_frame  <= 1'($urandom);
         end
      end
      @(negedge clock);
      req_bus.valid         <= 1'b1;
      req_bus.bin_magnitude <= mag;
      req_bus.bin_frequency <= freq;
      req_bus.end_of_frame  <= eof;
      do @(posedge clock); while (!req_bus.ready);
      bins_sent++;
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
   endtask

   task automatic random_frame();
      int               n;
      int               pick;
      int               band;
      int               lo;
      bit               silent;
      bit [MAG_W-1:0]   mag;
      bit [FREQ_W-1:0]  freq;
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 40) : $urandom_range(1, 8);
      silent = ($urandom_range(0, 11) == 0);
      sender_calm = ($urandom_range(0, 3) == 0);
      for (int k = 0; k < n; k++) begin
         case ($urandom_range(0, 3))
            0:       mag = MAG_W'($urandom);
            1:       mag = MAG_W'($urandom_range(0, 1000));
            2:       mag = MAG_W'($urandom >> $urandom_range(5, 31));
            default: mag = $urandom_range(0, 1) ? '1 : '0;
         endcase
         if (silent) mag = '0;
         pick = $urandom_range(0, 15);
         if (pick == 0) begin
            freq = FREQ_W'($urandom_range(2000, 22050));  // dropped bin
         end else begin
            band = $urandom_range(0, NUM_BANDS - 1);
            lo = (band == 0) ? 0 : BAND_EDGE_HZ[band-1];
            if (pick == 1)
               freq = FREQ_W'(BAND_EDGE_HZ[band] - 1);
            else if (pick == 2)
               freq = FREQ_W'(lo);
            else
               freq = FREQ_W'($urandom_range(lo, BAND_EDGE_HZ[band] - 1));
         end
         send_bin(mag, freq, k == n - 1);
      end
   endtask

   initial begin : stimulus
      int first_random;
      sb = new();
      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.bin_magnitude = '0;
      req_bus.bin_frequency = '0;
      req_bus.end_of_frame = 1'b0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // one full-scale bin alone
      send_bin('1, 15'd0, 1'b1);
      // both sides of every band edge; the closing bin at 2000 Hz is dropped
      for (int k = 0; k < 14; k++)
         send_bin((k == 13) ? '1 : MAG_W'((k + 1) * 12345), FREQ_W'(EDGE_PROBE_HZ[k]),
                  k == 13);
      // only a dropped bin: silent frame
      send_bin('1, 15'd22050, 1'b1);
      // equal sum/divisor in bands 0, 1 and 6
      send_bin(MAG_W'(200), 15'd50, 1'b0);
      send_bin(MAG_W'(150), 15'd150, 1'b0);
      send_bin(MAG_W'(600), 15'd1999, 1'b1);
      // zero magnitude closes the frame
      send_bin('0, 15'd700, 1'b1);
      wait_drained();

      first_random = bins_sent;
      while (bins_sent - first_random < RANDOM_BINS) begin
         random_frame();
         if ($urandom_range(0, 9) == 0) wait_drained();
      end
      wait_drained();
      repeat (400) @(posedge clock);

      if (sb.mismatches == 0 && sb.pending() == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

   initial begin : watchdog
      #10000000;
      $display("tb: failure");
      $finish;
   end

endmodule
